### design/melody_tone_generator_unit_assert.svh
// assertion helpers shared by the melody tone generator modules
`ifndef MELODY_TONE_GENERATOR_UNIT_ASSERT_SVH
`define MELODY_TONE_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked at every clock edge outside reset
`define MTG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every clock edge, reset included
`define MTG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTG_ASSERT(label, clk, rst, prop, msg)
`define MTG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/mtg_pkg.sv
package mtg_pkg;

   // store and result queue geometry
   localparam int unsigned MelodyDepthDefault = 256;
   localparam int unsigned OutQueueDepth      = 3;

   // item functions
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_START = 2'd2
   } func_type;

   // register indexes
   localparam logic CSR_ENABLE   = 1'b0;
   localparam logic CSR_DURATION = 1'b1;

   // register reset values
   localparam logic        EnableReset   = 1'b1;
   localparam logic [15:0] DurationReset = 16'd4096;

   // note codes
   localparam logic [3:0] CODE_SILENT     = 4'd0;
   localparam logic [3:0] CODE_STOP       = 4'd1;
   localparam logic [3:0] CODE_FIRST_TONE = 4'd2;
   localparam logic [3:0] CODE_LAST_TONE  = 4'd13;

   // phase lengths, four per tone code
   localparam int unsigned ToneEntries = 48;
   localparam logic [3:0] ToneLimits [ToneEntries] = '{
      4'd7,  4'd8,  4'd8,  4'd8,   4'd8,  4'd8,  4'd8,  4'd8,
      4'd8,  4'd9,  4'd9,  4'd9,   4'd9,  4'd9,  4'd9,  4'd10,
      4'd9,  4'd10, 4'd10, 4'd10,  4'd10, 4'd11, 4'd10, 4'd11,
      4'd11, 4'd11, 4'd11, 4'd11,  4'd11, 4'd12, 4'd12, 4'd12,
      4'd12, 4'd13, 4'd12, 4'd13,  4'd13, 4'd13, 4'd13, 4'd14,
      4'd14, 4'd14, 4'd14, 4'd14,  4'd14, 4'd15, 4'd15, 4'd15
   };

   function automatic logic [3:0] tone_limit(input logic [5:0] idx);
      return (idx < 6'(ToneEntries)) ? ToneLimits[idx] : 4'd0;
   endfunction

   typedef struct packed {
      logic [7:0]  address;
      logic [3:0]  code;
      logic        octave;
      logic        long_note;
      logic [1:0]  phase;
      logic [4:0]  phase_count;
      logic [16:0] duration_count;
      logic        finished;
   } note_state_type;

   typedef struct packed {
      logic       buzzer_on;
      logic       melody_finished;
      logic [7:0] note_address;
      logic [1:0] tone_phase;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [7:0] address;
      logic [5:0] word;
   } store_wr_type;

   typedef struct packed {
      logic       start;
      logic [7:0] start_address;
      logic [7:0] follow_address;
   } store_rd_type;

endpackage

### design/mtg_if.sv
interface mtg_req_if import mtg_pkg::*; ;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] address;
   logic [7:0] data;

   modport source (output valid, func, address, data, input ready);
   modport sink (input valid, func, address, data, output ready);
endinterface

interface mtg_rsp_if import mtg_pkg::*; ;
   logic       valid;
   logic       ready;
   logic       buzzer_on;
   logic       melody_finished;
   logic [7:0] note_address;
   logic [1:0] tone_phase;

   modport source (output valid, buzzer_on, melody_finished, note_address, tone_phase,
                   input ready);
   modport sink (input valid, buzzer_on, melody_finished, note_address, tone_phase,
                 output ready);
endinterface

interface mtg_csr_if import mtg_pkg::*; ;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

### design/mtg_store.sv
module mtg_store import mtg_pkg::*; #(
   parameter int unsigned MelodyDepth = MelodyDepthDefault
) (
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output logic [5:0]   rd_word
);

   localparam int unsigned IdxW    = (MelodyDepth > 1) ? $clog2(MelodyDepth) : 1;
   localparam logic [11:0] Depth12 = 12'(MelodyDepth);

   // address modulo depth, restoring steps on the 4-bit quotient
   function automatic logic [7:0] fold(input logic [7:0] a);
      logic [11:0] r;
      r = {4'b0, a};
      for (int k = 3; k >= 0; k--) begin
         if (r >= (Depth12 << k)) begin
            r = r - (Depth12 << k);
         end
      end
      return r[7:0];
   endfunction

   logic [5:0]      mem [MelodyDepth];
   logic [5:0]      rd_word_ff;
   logic [7:0]      wr_fold;
   logic [7:0]      rd_fold;
   logic [IdxW-1:0] wr_idx;
   logic [IdxW-1:0] rd_idx;

   assign wr_fold = fold(wr.address);
   assign rd_fold = fold(rd.start ? rd.start_address : rd.follow_address);
   assign wr_idx  = wr_fold[IdxW-1:0];
   assign rd_idx  = rd_fold[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.word;
      end
   end

   // write-first on a same-cycle hit
   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx == rd_idx)) begin
         rd_word_ff <= wr.word;
      end else begin
         rd_word_ff <= mem[rd_idx];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

### design/mtg_core.sv
module mtg_core import mtg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [1:0]     req_func,
   input  logic [7:0]     req_address,
   input  logic [7:0]     req_data,
   mtg_csr_if.sink        csr,
   input  logic [5:0]     rd_word,
   output store_wr_type   wr,
   output store_rd_type   rd,
   output logic           busy,
   output logic           push,
   output rsp_type        rsp
);

   logic           item_valid_ff;
   logic [1:0]     item_func_ff;
   logic [7:0]     item_address_ff;
   logic [5:0]     item_word_ff;
   logic           enable_ff;
   logic [15:0]    duration_ff;
   note_state_type state_ff;
   note_state_type state_in;

   logic [3:0]     tone_base;
   logic [4:0]     limit;
   logic [4:0]     count_tmp;
   logic [16:0]    dur_next;
   logic           expire;

   assign csr.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= EnableReset;
         duration_ff <= DurationReset;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_ENABLE:   enable_ff   <= csr.wdata[0];
            CSR_DURATION: duration_ff <= csr.wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_func_ff    <= req_func;
         item_address_ff <= req_address;
         item_word_ff    <= req_data[5:0];
      end
   end

   assign tone_base = state_ff.code - CODE_FIRST_TONE;
   assign limit     = state_ff.octave ? {tone_limit({tone_base, state_ff.phase}), 1'b0}
                                      : {1'b0, tone_limit({tone_base, state_ff.phase})};
   assign dur_next  = state_ff.duration_count + 17'd1;
   assign expire    = (!state_ff.long_note && (dur_next >= {1'b0, duration_ff}))
                   || (dur_next >= {duration_ff, 1'b0});

   always_comb begin
      state_in  = state_ff;
      count_tmp = state_ff.phase_count;
      wr        = '0;
      if (item_valid_ff) begin
         case (item_func_ff)
            FUNC_TICK: begin
               if (enable_ff) begin
                  if (state_ff.code == CODE_SILENT) begin
                     state_in.phase = 2'd0;
                  end else if (state_ff.code == CODE_STOP) begin
                     state_in.phase    = 2'd0;
                     state_in.finished = 1'b1;
                  end else if (state_ff.code inside {[CODE_FIRST_TONE:CODE_LAST_TONE]}) begin
                     if (state_ff.phase_count >= limit) begin
                        count_tmp      = 5'd0;
                        state_in.phase = state_ff.phase + 2'd1;
                     end
                     state_in.phase_count = count_tmp + 5'd1;
                  end
                  state_in.duration_count = dur_next;
                  if (expire) begin
                     state_in.address        = state_ff.address + 8'd1;
                     state_in.code           = rd_word[3:0];
                     state_in.octave         = rd_word[4];
                     state_in.long_note      = rd_word[5];
                     state_in.phase          = 2'd0;
                     state_in.phase_count    = 5'd0;
                     state_in.duration_count = 17'd0;
                  end
               end
            end
            FUNC_WRITE: begin
               wr.en      = 1'b1;
               wr.address = item_address_ff;
               wr.word    = item_word_ff;
            end
            FUNC_START: begin
               state_in.address        = item_address_ff;
               state_in.code           = rd_word[3:0];
               state_in.octave         = rd_word[4];
               state_in.long_note      = rd_word[5];
               state_in.phase          = 2'd0;
               state_in.phase_count    = 5'd0;
               state_in.duration_count = 17'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // the next item's note word: its start address, or the one after the note now held
   assign rd.start          = accept && (req_func == FUNC_START);
   assign rd.start_address  = req_address;
   assign rd.follow_address = state_in.address + 8'd1;

   assign busy                = item_valid_ff;
   assign push                = item_valid_ff;
   assign rsp.buzzer_on       = enable_ff & state_in.phase[0];
   assign rsp.melody_finished = state_in.finished;
   assign rsp.note_address    = state_in.address;
   assign rsp.tone_phase      = state_in.phase;

endmodule

### design/mtg_out_queue.sv
`include "melody_tone_generator_unit_assert.svh"

module mtg_out_queue import mtg_pkg::*; #(
   parameter int unsigned Depth = OutQueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsp_type                    push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output rsp_type                    head,
   output logic [$clog2(Depth+1)-1:0] count
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   rsp_type         slot [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   function automatic logic [PtrW-1:0] step(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= step(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= step(rd_ptr_ff);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = slot[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   `MTG_ASSERT(a_no_overflow, clock, reset, !(push && !pop && (count_ff == CntW'(Depth))), "result queue overflow")
   `MTG_ASSERT(a_no_underflow, clock, reset, pop |-> (count_ff != '0), "result queue underflow")
   `MTG_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)), "result queue count lost a push")

endmodule

### design/melody_tone_generator_unit.sv
// melody tone generator: buzzer melody sequencer with a note store
//
// req_if carries one transaction per item: func selects a tick, a store write
// (data bits 5..0 at address) or a start at address. rsp_if returns exactly one
// result per request transaction, in order: buzzer_on, melody_finished,
// note_address and tone_phase as they stand after that item.
// csr_if writes the enable (index 0) and the note duration in ticks (index 1);
// it is ready whenever reset is low and should only be written while no request
// is in flight.
// a taken request is registered as an item, and its result is written into the
// result queue before it is offered; a ready receiver pops it from the queue head.
// throughput: one item per cycle while req_if.ready is high; the next note word is
// prefetched from the store every cycle, so starts and note changes run without bubbles.
// a three-entry result queue absorbs receiver stalls; req_if.ready drops only
// once in-flight plus queued results reach three, and is held low in reset.
// reset: counters, flags and address clear, enable set, duration 4096; the
// note store keeps no reset value and must be written before it is read.
`include "melody_tone_generator_unit_assert.svh"

module melody_tone_generator_unit import mtg_pkg::*; #(
   parameter int unsigned MelodyDepth = MelodyDepthDefault
) (
   input logic      clock,
   input logic      reset,
   mtg_req_if.sink  req_if,
   mtg_rsp_if.source rsp_if,
   mtg_csr_if.sink  csr_if
);

   localparam int unsigned CntW = $clog2(OutQueueDepth + 1);

   logic            accept;
   logic            busy;
   logic            push;
   logic            pop;
   logic            not_empty;
   logic [CntW-1:0] q_count;
   logic [CntW:0]   occupancy;
   rsp_type         rsp;
   rsp_type         head;
   store_wr_type    wr;
   store_rd_type    rd;
   logic [5:0]      rd_word;

   // in-flight item plus queued results must leave room for one more
   assign occupancy     = {1'b0, q_count} + {{CntW{1'b0}}, busy};
   assign req_if.ready  = !reset && (occupancy < (CntW+1)'(OutQueueDepth));
   assign accept        = req_if.valid && req_if.ready;

   // note sequencing and configuration registers
   mtg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_func    (req_if.func),
      .req_address (req_if.address),
      .req_data    (req_if.data),
      .csr         (csr_if),
      .rd_word     (rd_word),
      .wr          (wr),
      .rd          (rd),
      .busy        (busy),
      .push        (push),
      .rsp         (rsp)
   );

   // note word memory with a registered read
   mtg_store #(
      .MelodyDepth (MelodyDepth)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_word (rd_word)
   );

   // result queue towards the receiver
   assign pop = rsp_if.valid && rsp_if.ready;

   mtg_out_queue #(
      .Depth (OutQueueDepth)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rsp),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_if.valid           = not_empty;
   assign rsp_if.buzzer_on       = head.buzzer_on;
   assign rsp_if.melody_finished = head.melody_finished;
   assign rsp_if.note_address    = head.note_address;
   assign rsp_if.tone_phase      = head.tone_phase;

endmodule
